@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned SPQ_CAPACITY = 64;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned POS_W        = 6;
   localparam int unsigned COUNT_W      = 7;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_FIND   = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic signed [31:0]  value;
   } spq_req_type;

   typedef struct packed {
      logic                success;
      logic [5:0]          position;
      logic signed [31:0]  head_value;
      logic                empty_res;
      logic [6:0]          entry_count;
   } spq_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_RESP
   } spq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request, run compares
      logic update;   // apply shift and form response
   } spq_cmd_type;

endpackage

@@ hw/rtl/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// Cell array with parallel compare, shift-insert and shift-remove.
// ----------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  spq_cmd_type cmd,
   input  spq_req_type req,
   output spq_rsp_type rsp
);

   localparam int unsigned IDX_W = $clog2(CAPACITY + 1);

   logic signed [31:0] cell_ff [CAPACITY];
   logic [IDX_W-1:0]   count_ff, count_in;
   spq_req_type        req_ff;
   logic [CAPACITY-1:0] lt_ff, eq_ff;   // per cell: valid & less / equal
   logic [CAPACITY-1:0] lt_in, eq_in;

   // compare stage
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = (i < count_ff) && (cell_ff[i] < req.value);
         eq_in[i] = (i < count_ff) && (cell_ff[i] == req.value);
      end
   end

   // priority: first equal cell; count of smaller cells (sorted => prefix)
   logic [IDX_W-1:0] ins_pos, eq_pos;
   logic             eq_hit, full;
   logic [CAPACITY-1:0] eq_first;
   always_comb begin
      ins_pos = '0;
      eq_pos  = '0;
      for (int i = 0; i < CAPACITY; i++)
         if (lt_ff[i]) ins_pos = IDX_W'(i + 1);
      for (int i = CAPACITY - 1; i >= 0; i--)
         if (eq_ff[i]) eq_pos = IDX_W'(i);
      eq_hit   = |eq_ff;
      // one-hot of first equal: lower cells are all smaller
      eq_first = eq_ff & ~(eq_ff << 1);
      full     = (count_ff == IDX_W'(CAPACITY));
   end

   logic do_ins, do_rem;
   assign do_ins = (req_ff.kind == KIND_INSERT) && !full;
   assign do_rem = (req_ff.kind == KIND_REMOVE) && eq_hit;

   always_comb begin
      count_in = count_ff;
      if (do_ins) count_in = count_ff + 1'b1;
      else if (do_rem) count_in = count_ff - 1'b1;
   end

   logic [CAPACITY-1:0] at_or_after_rem;
   always_comb begin
      at_or_after_rem = '0;
      for (int i = 0; i < CAPACITY; i++)
         at_or_after_rem[i] = (i == 0) ? eq_first[0]
                              : (eq_first[i] | at_or_after_rem[i-1]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
      end
      if (cmd.update) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (do_ins) begin
               if (i == ins_pos)      cell_ff[i] <= req_ff.value;
               else if (i > ins_pos && i > 0) cell_ff[i] <= cell_ff[(i > 0) ? i - 1 : 0];
            end else if (do_rem) begin
               if (at_or_after_rem[i] && i < CAPACITY - 1)
                  cell_ff[i] <= cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.update) count_ff <= count_in;
   end

   // result register
   spq_rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff.success  <= do_ins || eq_hit && (req_ff.kind == KIND_REMOVE
                            || req_ff.kind == KIND_FIND);
         rsp_ff.position <= do_ins ? ins_pos[POS_W-1:0]
                          : ((req_ff.kind == KIND_FIND && eq_hit)
                             ? eq_pos[POS_W-1:0] : '0);
         rsp_ff.entry_count <= COUNT_W'(count_in);
         rsp_ff.empty_res   <= (count_in == '0);
      end
   end

   // head is read from the updated cell array
   assign rsp = '{success: rsp_ff.success, position: rsp_ff.position,
                  head_value: (count_ff == '0) ? 32'sd0 : cell_ff[0],
                  empty_res: rsp_ff.empty_res, entry_count: rsp_ff.entry_count};

endmodule

@@ hw/rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: compare step, update step, response hold.
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_cmd_type cmd
);

   spq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.load   = 1'b0;
      cmd.update = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            // take next beat as this one leaves
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/sorted_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Sorted list priority queue over a cell array with parallel compare.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload       | Handshake
// req     | in  | spq_req_type  | req_valid / req_ready
// rsp     | out | spq_rsp_type  | rsp_valid / rsp_ready
//
// Each beat takes a compare against all cells, then a shift.
// The result is offered in the cycle after the shift; the next request is
// taken in the cycle the result is accepted, so beats can run back to back.
// Reset clears the entry count and the sequencer state; cells hold no reset value.
// A stalled rsp holds the unit; requests wait until it is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  spq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_rsp_type rsp_data
);

   spq_cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd
   );

   spq_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock, .reset, .cmd, .req(req_data), .rsp(rsp_data)
   );

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.update)) else $error("load and update together");

   a_upd_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid) else $error("update not followed by rsp");

   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.empty_res == (rsp_data.entry_count == 7'd0)))
      else $error("empty flag mismatch");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Regression for sorted_priority_queue_unit: directed and random insert,
// remove and find beats checked against an ordered-array queue model.
// ----------------------------------------------------------------------------
module tb_top;
   import spq_pkg::*;

   class spq_scoreboard;
      logic signed [31:0] cells[$];
      spq_rsp_type        pending[$];
      int                 errors;

      function void note_request(spq_req_type r);
         spq_rsp_type e;
         int          p;
         bit          hit;
         p   = 0;
         hit = 0;
         e   = '0;
         case (r.kind)
            KIND_INSERT: begin
               if (cells.size() < SPQ_CAPACITY) begin
                  while (p < cells.size() && cells[p] < r.value) p++;
                  cells.insert(p, r.value);
                  e.success  = 1'b1;
                  e.position = p[5:0];
               end
            end
            KIND_REMOVE, KIND_FIND: begin
               for (int i = 0; i < cells.size() && !hit; i++)
                  if (cells[i] == r.value) begin
                     hit = 1;
                     p   = i;
                  end
               if (hit) begin
                  e.success = 1'b1;
                  if (r.kind == KIND_REMOVE) cells.delete(p);
                  else e.position = p[5:0];
               end
            end
            default: ;
         endcase
         e.head_value  = cells.size() ? cells[0] : 32'sd0;
         e.empty_res   = (cells.size() == 0);
         e.entry_count = COUNT_W'(cells.size());
         pending.push_back(e);
      endfunction

      function void check_response(spq_rsp_type got);
         spq_rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected beat", 32'(got.entry_count), 32'd0);
            return;
         end
         e = pending.pop_front();
         if (got.success !== e.success)
            report("success", 32'(got.success), 32'(e.success));
         if (got.position !== e.position)
            report("position", 32'(got.position), 32'(e.position));
         if (got.head_value !== e.head_value) report("head", got.head_value, e.head_value);
         if (got.empty_res !== e.empty_res)
            report("empty", 32'(got.empty_res), 32'(e.empty_res));
         if (got.entry_count !== e.entry_count)
            report("count", 32'(got.entry_count), 32'(e.entry_count));
      endfunction

      function void report(string field, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h want %h", field, got, want);
         errors++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   spq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   spq_rsp_type rsp_data;

   spq_scoreboard sb = new();
   bit            quiet;      // no idling in the final part
   bit            hold_rsp;   // long receiver stall

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   sorted_priority_queue_unit dut (.*);

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // receiver: random bursts of stall
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   // valid stays up after a beat; it drops only in an idle burst or a drain
   task automatic send_beat(logic [1:0] k, logic signed [31:0] v);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid     <= 1;
      req_data.kind <= k;
      req_data.value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_queue();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 15) - 8;
         2: return sb.cells.size() ? sb.cells[$urandom_range(0, sb.cells.size() - 1)] : 0;
         default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
   endfunction

   initial begin
      logic [1:0] k;
      int         r;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty queue, extremes, duplicates, absent values, unused kind
      send_beat(KIND_FIND, 0);
      send_beat(KIND_REMOVE, 5);
      send_beat(KIND_INSERT, 32'sh7fffffff);
      send_beat(KIND_INSERT, 32'sh80000000);
      send_beat(KIND_INSERT, 0);
      send_beat(KIND_INSERT, 0);
      send_beat(KIND_INSERT, -1);
      send_beat(KIND_FIND, 0);
      send_beat(KIND_FIND, 32'sh7fffffff);
      send_beat(KIND_FIND, 7);
      send_beat(2'd3, 32'shffffffff);
      send_beat(KIND_REMOVE, 0);
      send_beat(KIND_REMOVE, 32'sh80000000);
      send_beat(KIND_REMOVE, 32'sh12345678);
      // fill past capacity, beginning under a long receiver stall
      hold_rsp = 1;
      for (int i = 0; i < SPQ_CAPACITY + 4; i++) send_beat(KIND_INSERT, $urandom);
      drain_queue();
      send_beat(KIND_FIND, sb.cells[SPQ_CAPACITY - 1]);
      for (int i = 0; i < SPQ_CAPACITY; i++) send_beat(KIND_REMOVE, sb.cells[0]);
      drain_queue();
      // random phase
      for (int i = 0; i < 600; i++) begin
         if (i >= 520) quiet = 1;
         r = $urandom_range(0, 99);
         if (r < 45) k = KIND_INSERT;
         else if (r < 75) k = KIND_REMOVE;
         else if (r < 97) k = KIND_FIND;
         else k = 2'd3;
         send_beat(k, pick_value());
      end
      drain_queue();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("sorted_priority_queue_unit regression: pass");
      else
         $display("sorted_priority_queue_unit regression: fail");
      $finish;
   end

   initial begin
      #400000;
      $display("sorted_priority_queue_unit regression: fail");
      $finish;
   end
endmodule

@@ files.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_datapath.sv
hw/rtl/spq_ctrl.sv
hw/rtl/sorted_priority_queue_unit.sv
dv/tb_top.sv
